@@ sv/bit_vector_range_engine_macros.svh @@
// assertion macros for the bit vector range engine
`ifndef BIT_VECTOR_RANGE_ENGINE_MACROS_SVH
`define BIT_VECTOR_RANGE_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define BVR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BVR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BVR_ASSERT_IMP(lbl, ante, cons)
`define BVR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ sv/bvr_pkg.sv @@
package bvr_pkg;

  typedef enum logic [3:0] {
    OP_FILL  = 4'd0,
    OP_FLIP  = 4'd1,
    OP_AND   = 4'd2,
    OP_OR    = 4'd3,
    OP_XOR   = 4'd4,
    OP_COUNT = 4'd5,
    OP_EMPTY = 4'd6,
    OP_NSET  = 4'd7,
    OP_NCLR  = 4'd8,
    OP_READ  = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  localparam logic [10:0] FOUND_NONE = 11'h7ff;
  localparam int unsigned WORD_BITS = 64;

  typedef struct packed {
    logic [3:0]  op;
    logic        trim;
    logic        fill;
    logic [63:0] operand;
  } word_ctl_t;

  typedef struct packed {
    logic       we;
    logic       hit;
    logic [5:0] pos;
    logic [6:0] pop;
  } word_res_t;

endpackage

@@ sv/bvr_store.sv @@
module bvr_store
  import bvr_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [63:0]          rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bvr_word_unit.sv @@
module bvr_word_unit
  import bvr_pkg::*;
#(
  parameter int unsigned CW = 12
) (
  input  word_ctl_t     ctl_i,
  input  logic [CW-1:0] base_i,
  input  logic [CW-1:0] from_i,
  input  logic [CW-1:0] to_i,
  input  logic [CW-1:0] size_i,
  input  logic [63:0]   rdata_i,
  output logic [63:0]   wdata_o,
  output word_res_t     res_o
);

  logic [63:0]   size_m;
  logic [63:0]   range_m;
  logic [63:0]   after_m;
  logic [63:0]   cand;
  logic [63:0]   opw;
  logic [CW-1:0] idx;

  always_comb begin
    for (int b = 0; b < 64; b++) begin
      idx        = base_i + CW'(b);
      size_m[b]  = idx < size_i;
      range_m[b] = (idx >= from_i) && (idx < to_i);
      after_m[b] = idx > from_i;
    end
    opw  = ctl_i.operand & size_m;
    cand = ((ctl_i.op == OP_NSET) ? rdata_i : ~rdata_i) & size_m & after_m;

    wdata_o   = rdata_i;
    res_o.we  = 1'b0;
    if (ctl_i.trim) begin
      wdata_o  = rdata_i & size_m;
      res_o.we = 1'b1;
    end else begin
      case (ctl_i.op)
        OP_FILL: begin
          wdata_o  = ctl_i.fill ? (rdata_i | range_m) : (rdata_i & ~range_m);
          res_o.we = 1'b1;
        end
        OP_FLIP: begin
          wdata_o  = rdata_i ^ range_m;
          res_o.we = 1'b1;
        end
        OP_AND: begin
          wdata_o  = rdata_i & opw;
          res_o.we = 1'b1;
        end
        OP_OR: begin
          wdata_o  = rdata_i | opw;
          res_o.we = 1'b1;
        end
        OP_XOR: begin
          wdata_o  = rdata_i ^ opw;
          res_o.we = 1'b1;
        end
        default: ;
      endcase
    end

    res_o.pop = 7'($countones(rdata_i & size_m));
    res_o.hit = |cand;
    res_o.pos = '0;
    for (int b = 63; b >= 0; b--) begin
      if (cand[b]) begin
        res_o.pos = 6'(b);
      end
    end
  end

endmodule

@@ sv/bit_vector_range_engine.sv @@
// the engine walks the store one word per cycle
// fill, flip, count, empty and search walk every word of the store
// logic ops and read touch one word; bad requests walk no word
// a configuration write while idle trims the store in a walk of every word, busy high during the walk
// after reset a clearing pass of one word per cycle runs, busy high until it is done
// one request at a time; the receiver cannot stall, done_o lasts one cycle
module bit_vector_range_engine
  import bvr_pkg::*;
#(
  parameter int unsigned SET_BITS = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  logic [3:0]   opcode_i,
  input  logic [11:0]  from_index_i,
  input  logic [10:0]  to_index_i,
  input  logic         fill_value_i,
  input  logic [3:0]   word_index_i,
  input  logic [63:0]  operand_word_i,
  output logic         done_o,
  output logic [10:0]  found_index_o,
  output logic [10:0]  bit_count_o,
  output logic         is_empty_o,
  output logic [63:0]  read_data_o,
  output logic         range_error_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned NW = (SET_BITS + 63) / 64;
  localparam int unsigned AW = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned CW = (AW + 7 > 12) ? AW + 7 : 12;

  state_e        state_q, state_d;
  logic [3:0]    op_q, op_d;
  logic          trim_q, trim_d;
  logic          clr_q, clr_d;
  logic          fill_q, fill_d;
  logic [CW-1:0] from_q, from_d;
  logic [CW-1:0] to_q, to_d;
  logic [63:0]   opw_q, opw_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] last_q, last_d;
  logic          pv_q, pv_d;
  logic [AW-1:0] pa_q, pa_d;
  logic [CW-1:0] acc_q, acc_d, acc_n;
  logic          hit_q, hit_d, hit_n;
  logic [CW-1:0] found_q, found_d, found_n;
  logic [63:0]   rd_q, rd_d, rd_n;
  logic          err_q, err_d;
  logic [10:0]   active_q, active_d;
  logic          done_q, done_d;
  logic [10:0]   fo_q, fo_d;
  logic [10:0]   bc_q, bc_d;
  logic          em_q, em_d;
  logic [63:0]   ro_q, ro_d;
  logic          re_q, re_d;

  logic [CW-1:0] size;
  logic [CW-1:0] in_from;
  logic [CW-1:0] in_to;
  logic          in_err;
  logic          widx_ok;
  logic          cfg_we;
  logic [63:0]   rdata;
  logic [63:0]   wdata;
  word_ctl_t     ctl;
  word_res_t     res;
  logic [CW-1:0] base;

  assign size    = (CW'(active_q) < CW'(SET_BITS)) ? CW'(active_q) : CW'(SET_BITS);
  assign in_from = CW'(from_index_i[10:0]);
  assign in_to   = CW'(to_index_i);
  assign in_err  = from_index_i[11] || (in_from > in_to) || (in_to > size);
  assign widx_ok = 32'(word_index_i) < 32'(NW);
  assign cfg_we  = psel && penable && pwrite && (paddr == 3'd0);
  assign pready  = 1'b1;
  assign prdata  = (paddr == 3'd0) ? 32'(active_q) : '0;
  assign busy    = state_q != ST_IDLE;
  assign base    = CW'(pa_q) << 6;

  assign ctl.op      = op_q;
  assign ctl.trim    = trim_q;
  assign ctl.fill    = fill_q;
  assign ctl.operand = opw_q;

  bvr_word_unit #(.CW(CW)) u_word (
    .ctl_i   (ctl),
    .base_i  (base),
    .from_i  (from_q),
    .to_i    (to_q),
    .size_i  (clr_q ? '0 : size),
    .rdata_i (rdata),
    .wdata_o (wdata),
    .res_o   (res)
  );

  bvr_store #(.DEPTH(NW), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (pv_q && res.we),
    .waddr_i (pa_q),
    .wdata_i (wdata),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_comb begin
    acc_n   = acc_q + (pv_q ? CW'(res.pop) : '0);
    hit_n   = hit_q;
    found_n = found_q;
    if (pv_q && !hit_q && res.hit) begin
      hit_n   = 1'b1;
      found_n = base + CW'(res.pos);
    end
    rd_n = (pv_q && op_q == OP_READ) ? rdata : rd_q;
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    trim_d   = trim_q;
    clr_d    = clr_q;
    fill_d   = fill_q;
    from_d   = from_q;
    to_d     = to_q;
    opw_d    = opw_q;
    addr_d   = addr_q;
    last_d   = last_q;
    pv_d     = 1'b0;
    pa_d     = pa_q;
    acc_d    = acc_q;
    hit_d    = hit_q;
    found_d  = found_q;
    rd_d     = rd_q;
    err_d    = err_q;
    active_d = cfg_we ? pwdata[10:0] : active_q;
    done_d   = 1'b0;
    fo_d     = fo_q;
    bc_d     = bc_q;
    em_d     = em_q;
    ro_d     = ro_q;
    re_d     = re_q;
    case (state_q)
      ST_IDLE: begin
        if (cfg_we) begin
          trim_d  = 1'b1;
          clr_d   = 1'b0;
          addr_d  = '0;
          last_d  = AW'(NW - 1);
          state_d = ST_RUN;
        end else if (start) begin
          op_d    = opcode_i;
          trim_d  = 1'b0;
          clr_d   = 1'b0;
          fill_d  = fill_value_i;
          from_d  = in_from;
          to_d    = in_to;
          opw_d   = operand_word_i;
          acc_d   = '0;
          hit_d   = 1'b0;
          found_d = '0;
          rd_d    = '0;
          err_d   = 1'b0;
          addr_d  = '0;
          last_d  = AW'(NW - 1);
          state_d = ST_FIN;
          case (opcode_i)
            OP_FILL, OP_FLIP: begin
              err_d = in_err;
              if (!in_err) begin
                state_d = ST_RUN;
              end
            end
            OP_AND, OP_OR, OP_XOR, OP_READ: begin
              addr_d = AW'(word_index_i);
              last_d = AW'(word_index_i);
              if (widx_ok) begin
                state_d = ST_RUN;
              end
            end
            OP_COUNT, OP_EMPTY: begin
              state_d = ST_RUN;
            end
            OP_NSET, OP_NCLR: begin
              if (!from_index_i[11]) begin
                state_d = ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        pv_d    = 1'b1;
        pa_d    = addr_q;
        acc_d   = acc_n;
        hit_d   = hit_n;
        found_d = found_n;
        rd_d    = rd_n;
        if (addr_q == last_q) begin
          state_d = ST_FIN;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
        acc_d   = acc_n;
        hit_d   = hit_n;
        found_d = found_n;
        rd_d    = rd_n;
        trim_d  = 1'b0;
        clr_d   = 1'b0;
        if (!trim_q) begin
          done_d = 1'b1;
          fo_d   = '0;
          bc_d   = '0;
          em_d   = 1'b0;
          ro_d   = '0;
          re_d   = err_q;
          case (op_q)
            OP_NSET, OP_NCLR: fo_d = hit_n ? found_n[10:0] : FOUND_NONE;
            OP_COUNT: bc_d = acc_n[10:0];
            OP_EMPTY: em_d = acc_n == '0;
            OP_READ: ro_d = rd_n;
            default: ;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_RUN;
      trim_q   <= 1'b1;
      clr_q    <= 1'b1;
      addr_q   <= '0;
      last_q   <= AW'(NW - 1);
      pv_q     <= 1'b0;
      active_q <= 11'd1024;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      trim_q   <= trim_d;
      clr_q    <= clr_d;
      addr_q   <= addr_d;
      last_q   <= last_d;
      pv_q     <= pv_d;
      active_q <= active_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    fill_q  <= fill_d;
    from_q  <= from_d;
    to_q    <= to_d;
    opw_q   <= opw_d;
    pa_q    <= pa_d;
    acc_q   <= acc_d;
    hit_q   <= hit_d;
    found_q <= found_d;
    rd_q    <= rd_d;
    err_q   <= err_d;
    fo_q    <= fo_d;
    bc_q    <= bc_d;
    em_q    <= em_d;
    ro_q    <= ro_d;
    re_q    <= re_d;
  end

  assign done_o        = done_q;
  assign found_index_o = fo_q;
  assign bit_count_o   = bc_q;
  assign is_empty_o    = em_q;
  assign read_data_o   = ro_q;
  assign range_error_o = re_q;

`include "bit_vector_range_engine_macros.svh"

  `BVR_ASSERT_NXT(a_done_single, done_o, !done_o)
  `BVR_ASSERT_NXT(a_start_busy, start && !busy && !cfg_we, busy)
  `BVR_ASSERT_IMP(a_no_idle_write, pv_q && res.we, state_q != ST_IDLE)
  `BVR_ASSERT_IMP(a_err_quiet, done_o && range_error_o, bit_count_o == '0 && found_index_o == '0)

endmodule
